// ===== rtl/bsgc_pkg.sv =====
package bsgc_pkg;

    localparam int NUM_AGENTS = 5;
    localparam int AGENT_W    = $clog2(NUM_AGENTS);
    localparam int CLAIM_W    = NUM_AGENTS * NUM_AGENTS;
    localparam int IDX_FIELD_W   = 3;
    localparam int AVAIL_FIELD_W = 5;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W = ((2 * IDX_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + AVAIL_FIELD_W + 7) / 8) * 8;

    typedef logic [NUM_AGENTS-1:0] row_t;
    typedef row_t [NUM_AGENTS-1:0] matrix_t;
    typedef logic [AGENT_W-1:0]    agent_idx_t;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED  = 2'd0,
        STAT_BUSY     = 2'd1,
        STAT_UNSAFE   = 2'd2,
        STAT_RELEASED = 2'd3
    } status_t;

    // start/ack handshake toward the safety checker
    typedef struct packed {
        logic       start;
        logic       ack;
        agent_idx_t proc_idx;
        agent_idx_t res_idx;
    } chk_ctrl_t;

    typedef struct packed {
        logic done;
        logic safe;
    } chk_stat_t;

    // ring claim: process p may hold resources p and p+1 (wrapping)
    function automatic matrix_t ring_claim();
        matrix_t m;
        m = '0;
        for (int p = 0; p < NUM_AGENTS; p++) begin
            m[p][p] = 1'b1;
            if (p == NUM_AGENTS - 1) begin
                m[p][0] = 1'b1;
            end else begin
                m[p][p+1] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam matrix_t RESET_CLAIM = ring_claim();

endpackage

// ===== rtl/bankers_safe_grant_checker.sv =====
// Banker's-algorithm grant unit for single-unit resources.
//
// Input channel (s_*): one transfer per request or release. s_tuser is the
// opcode (0 acquire, 1 release); s_tdata carries process and resource index.
// Output channel (m_*): one transfer per input item with the status code
// (granted, denied busy, denied unsafe, released) and the available mask
// after the item.
// Config: cfg_wr_en writes the claim matrix (bit p*5+r); only the claim
// changes, need rows and available mask keep their values.
// Timing: a release, an out-of-range item or a busy denial is answered in the
// cycle after the input transfer. A request that reaches the safety check
// is answered after the checker's passes of the shared row-fit compare unit
// (one process finished per pass) and its done state, which posts the result
// once the output slot is free. One item in flight at a time; s_tready is low
// while a check runs.
// Stalls: the result sits in an output register; the next item is taken
// while the receiver drains it, and a finished check waits for a free slot.
// Reset (aresetn low, synchronous): claim and need rows go to the ring
// claim, all resources available, output channel empty.
module bankers_safe_grant_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsgc_pkg::S_TDATA_W-1:0]  s_tdata,   // [2:0] process_index, [5:3] resource_index
    input  logic                            s_tuser,   // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsgc_pkg::M_TDATA_W-1:0]  m_tdata,   // [1:0] status, [6:2] available_after
    input  logic                            cfg_wr_en,
    input  logic [bsgc_pkg::CLAIM_W-1:0]    cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_CHECK = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    bsgc_pkg::matrix_t    claim_reg;
    bsgc_pkg::matrix_t    need_reg, need_next;
    bsgc_pkg::row_t       avail_reg, avail_next;
    bsgc_pkg::agent_idx_t proc_reg, proc_next;
    bsgc_pkg::agent_idx_t res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    bsgc_pkg::status_t    status_reg, status_next;
    bsgc_pkg::row_t       out_avail_reg, out_avail_next;

    bsgc_pkg::chk_ctrl_t  chk_ctrl;
    bsgc_pkg::chk_stat_t  chk_stat;

    // input field decode
    logic [bsgc_pkg::IDX_FIELD_W-1:0] in_proc, in_res;
    bsgc_pkg::agent_idx_t             in_p, in_r;
    bsgc_pkg::row_t                   in_bit, cur_bit;
    logic                             in_range, in_fire, out_free;

    logic [bsgc_pkg::NUM_AGENTS+bsgc_pkg::AVAIL_FIELD_W-1:0] avail_ext;

    assign in_proc  = s_tdata[bsgc_pkg::IDX_FIELD_W-1:0];
    assign in_res   = s_tdata[2*bsgc_pkg::IDX_FIELD_W-1:bsgc_pkg::IDX_FIELD_W];
    assign in_p     = in_proc[bsgc_pkg::AGENT_W-1:0];
    assign in_r     = in_res[bsgc_pkg::AGENT_W-1:0];
    assign in_range = (32'(in_proc) < bsgc_pkg::NUM_AGENTS) &&
                      (32'(in_res) < bsgc_pkg::NUM_AGENTS);
    assign in_bit   = bsgc_pkg::row_t'(1) << in_r;
    assign cur_bit  = bsgc_pkg::row_t'(1) << res_reg;

    // output slot is free if empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        need_next      = need_reg;
        avail_next     = avail_reg;
        proc_next      = proc_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        status_next    = status_reg;
        out_avail_next = out_avail_reg;
        chk_ctrl       = '0;
        chk_ctrl.proc_idx = in_p;
        chk_ctrl.res_idx  = in_r;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    proc_next = in_p;
                    res_next  = in_r;
                    if (bsgc_pkg::opcode_t'(s_tuser) == bsgc_pkg::OP_RELEASE) begin
                        if (in_range) begin
                            // need bit back to claim bit, resource freed
                            need_next[in_p] = (need_reg[in_p] & ~in_bit) |
                                              (claim_reg[in_p] & in_bit);
                            avail_next      = avail_reg | in_bit;
                        end
                        status_next    = bsgc_pkg::STAT_RELEASED;
                        out_avail_next = avail_next;
                        m_valid_next   = 1'b1;
                    end else if (!in_range || !(|(avail_reg & in_bit))) begin
                        status_next    = bsgc_pkg::STAT_BUSY;
                        out_avail_next = avail_reg;
                        m_valid_next   = 1'b1;
                    end else begin
                        chk_ctrl.start = 1'b1;
                        state_next     = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (chk_stat.done && out_free) begin
                    chk_ctrl.ack = 1'b1;
                    if (chk_stat.safe) begin
                        need_next[proc_reg] = need_reg[proc_reg] & ~cur_bit;
                        avail_next          = avail_reg & ~cur_bit;
                        status_next         = bsgc_pkg::STAT_GRANTED;
                    end else begin
                        status_next = bsgc_pkg::STAT_UNSAFE;
                    end
                    out_avail_next = avail_next;
                    m_valid_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            claim_reg   <= bsgc_pkg::RESET_CLAIM;
            need_reg    <= bsgc_pkg::RESET_CLAIM;
            avail_reg   <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            need_reg    <= need_next;
            avail_reg   <= avail_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                claim_reg <= bsgc_pkg::matrix_t'(cfg_wr_data);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        proc_reg      <= proc_next;
        res_reg       <= res_next;
        status_reg    <= status_next;
        out_avail_reg <= out_avail_next;
    end

    bsgc_safety_unit u_safety (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (chk_ctrl),
        .need_in  (need_reg),
        .avail_in (avail_reg),
        .claim_in (claim_reg),
        .stat     (chk_stat)
    );

    // available mask fitted to the 5-bit result field
    assign avail_ext = {{bsgc_pkg::AVAIL_FIELD_W{1'b0}}, out_avail_reg};
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = bsgc_pkg::M_TDATA_W'({avail_ext[bsgc_pkg::AVAIL_FIELD_W-1:0],
                                             status_reg});

endmodule

// ===== rtl/bsgc_safety_unit.sv =====
module bsgc_safety_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  bsgc_pkg::chk_ctrl_t ctrl,
    input  bsgc_pkg::matrix_t   need_in,
    input  bsgc_pkg::row_t      avail_in,
    input  bsgc_pkg::matrix_t   claim_in,
    output bsgc_pkg::chk_stat_t stat
);

    typedef enum logic [2:0] {
        CK_IDLE = 3'b001,
        CK_RUN  = 3'b010,
        CK_DONE = 3'b100
    } ck_state_t;

    ck_state_t         ck_state_reg, ck_state_next;
    bsgc_pkg::matrix_t need_reg;
    bsgc_pkg::row_t    avail_reg, avail_next;
    bsgc_pkg::row_t    done_reg, done_next;
    logic              safe_reg, safe_next;

    bsgc_pkg::row_t    fit;
    bsgc_pkg::row_t    pick;
    logic              found;

    bsgc_pkg::matrix_t trial_need;
    bsgc_pkg::row_t    trial_avail;

    // tentative grant applied to the incoming state
    always_comb begin
        trial_need                            = need_in;
        trial_need[ctrl.proc_idx][ctrl.res_idx] = 1'b0;
        trial_avail                           = avail_in;
        trial_avail[ctrl.res_idx]             = 1'b0;
    end

    // shared fit compare: all rows at once, lowest unfinished fitting row wins
    always_comb begin
        found      = 1'b0;
        pick       = '0;
        avail_next = avail_reg;
        for (int i = 0; i < bsgc_pkg::NUM_AGENTS; i++) begin
            fit[i] = !done_reg[i] && ((need_reg[i] & ~avail_reg) == '0);
            if (fit[i] && !found) begin
                found      = 1'b1;
                pick[i]    = 1'b1;
                avail_next = avail_reg | claim_in[i];
            end
        end
        done_next = done_reg | pick;
    end

    always_comb begin
        ck_state_next = ck_state_reg;
        safe_next     = safe_reg;
        unique case (ck_state_reg)
            CK_IDLE: begin
                if (ctrl.start) begin
                    ck_state_next = CK_RUN;
                end
            end
            CK_RUN: begin
                if (!found) begin
                    safe_next     = 1'b0;
                    ck_state_next = CK_DONE;
                end else if (&done_next) begin
                    safe_next     = 1'b1;
                    ck_state_next = CK_DONE;
                end
            end
            CK_DONE: begin
                if (ctrl.ack) begin
                    ck_state_next = CK_IDLE;
                end
            end
            default: ck_state_next = CK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ck_state_reg <= CK_IDLE;
            safe_reg     <= 1'b0;
        end else begin
            ck_state_reg <= ck_state_next;
            safe_reg     <= safe_next;
        end
    end

    // working copies: tentative grant applied on load
    always_ff @(posedge aclk) begin
        if (ck_state_reg == CK_IDLE && ctrl.start) begin
            need_reg  <= trial_need;
            avail_reg <= trial_avail;
            done_reg  <= '0;
        end else if (ck_state_reg == CK_RUN) begin
            avail_reg <= avail_next;
            done_reg  <= done_next;
        end
    end

    assign stat.done = (ck_state_reg == CK_DONE);
    assign stat.safe = safe_reg;

endmodule

// ===== dv/bankers_safe_grant_checker_test.sv =====
module bankers_safe_grant_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bsgc_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_CYCLES  = 16;    // margin beyond the longest check
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 156;   // ~1250 random items over all phases

    // One expected response transfer.
    typedef struct {
        status_t                  status;
        logic [AVAIL_FIELD_W-1:0] avail;
    } grant_result_t;

    // Tracks claim, need rows and free mask; predicts one response per
    // accepted request/release and checks responses in order.
    class grant_scoreboard;
        logic [CLAIM_W-1:0] claim;
        row_t               need [NUM_AGENTS];
        row_t               avail;
        grant_result_t      expected_q [$];
        int                 errors;

        function new();
            claim = '0;
            // ring claim: process p owns resources p and p+1 mod N
            for (int p = 0; p < NUM_AGENTS; p++) begin
                claim[p*NUM_AGENTS + p] = 1'b1;
                claim[p*NUM_AGENTS + (p + 1) % NUM_AGENTS] = 1'b1;
            end
            for (int p = 0; p < NUM_AGENTS; p++) begin
                need[p] = claim_row(p);
            end
            avail  = '1;
            errors = 0;
        endfunction

        function row_t claim_row(int p);
            return claim[p*NUM_AGENTS +: NUM_AGENTS];
        endfunction

        // Only the claim changes; need rows and free mask are kept.
        function void write_claim(logic [CLAIM_W-1:0] value);
            claim = value;
        endfunction

        // Banker's safety pass on a tentative grant of r to p.
        function bit grant_is_safe(int p, int r);
            row_t                  trial_need [NUM_AGENTS];
            row_t                  trial_avail;
            logic [NUM_AGENTS-1:0] finished;
            bit                    found;
            for (int i = 0; i < NUM_AGENTS; i++) begin
                trial_need[i] = need[i];
            end
            trial_need[p][r] = 1'b0;
            trial_avail      = avail;
            trial_avail[r]   = 1'b0;
            finished         = '0;
            for (int round = 0; round < NUM_AGENTS; round++) begin
                found = 1'b0;
                // lowest-numbered unfinished process whose need fits
                for (int i = 0; i < NUM_AGENTS; i++) begin
                    if (!found && !finished[i] && (trial_need[i] & ~trial_avail) == '0) begin
                        finished[i] = 1'b1;
                        trial_avail = trial_avail | claim_row(i);
                        found       = 1'b1;
                    end
                end
                if (!found) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_item(logic op, logic [2:0] p, logic [2:0] r);
            grant_result_t res;
            row_t          own;
            bit            in_range;
            in_range = (p < NUM_AGENTS) && (r < NUM_AGENTS);
            if (opcode_t'(op) == OP_RELEASE) begin
                res.status = STAT_RELEASED;
                if (in_range) begin
                    own        = claim_row(p);
                    need[p][r] = own[r];
                    avail[r]   = 1'b1;
                end
            end else if (!in_range || !avail[r]) begin
                res.status = STAT_BUSY;
            end else if (!grant_is_safe(p, r)) begin
                res.status = STAT_UNSAFE;
            end else begin
                res.status = STAT_GRANTED;
                need[p][r] = 1'b0;
                avail[r]   = 1'b0;
            end
            res.avail = avail;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            grant_result_t exp_res;
            status_t       got_status;
            logic [AVAIL_FIELD_W-1:0] got_avail;
            got_status = status_t'(data[STATUS_W-1:0]);
            got_avail  = data[STATUS_W +: AVAIL_FIELD_W];
            if (expected_q.size() == 0) begin
                $display("%0t: response with nothing outstanding, tdata %h", $time, data);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got_status !== exp_res.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_res.status, got_status);
                errors++;
            end
            if (got_avail !== exp_res.avail) begin
                $display("%0t: available_after expected %b actual %b",
                         $time, exp_res.avail, got_avail);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic                   s_tuser     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en   = 1'b0;
    logic [CLAIM_W-1:0]     cfg_wr_data = '0;

    grant_scoreboard sb = new();
    bit              idle_on = 1'b1;   // cleared for stretches with no gaps
    int              cycles  = 0;
    int              stall_left = 0;

    bankers_safe_grant_checker u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [2:0] process_index, [5:3] resource_index
        .s_tuser     (s_tuser),     // [0] opcode
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // [1:0] status, [6:2] available_after
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (!idle_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Random set bit of a nonzero row.
    function automatic int pick_bit(row_t row);
        int r;
        do begin
            r = $urandom_range(0, NUM_AGENTS - 1);
        end while (!row[r]);
        return r;
    endfunction

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver backpressure: random stalls on m_tready.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: values read here are the ones that held just before the edge.
    // Response checked before the new input is noted; a response never
    // belongs to an input accepted at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_item(s_tuser, s_tdata[2:0], s_tdata[5:3]);
            end
            if (cfg_wr_en) begin
                sb.write_claim(cfg_wr_data);
            end
        end
    end

    // One input transfer; valid stays high into the next item when no gap.
    task automatic send_item(opcode_t op, int p, int r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, 3'(r), 3'(p)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending until every outstanding response is back; the extra edge
    // lets the monitor note the last accepted item first.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_claim_reg(logic [CLAIM_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly well-formed traffic: requests inside the claim, releases of
    // held resources; the rest random, including out-of-range indices.
    task automatic send_random_item();
        opcode_t op;
        int      p;
        int      r;
        row_t    own;
        row_t    held;
        op = ($urandom_range(0, 99) < 55) ? OP_ACQUIRE : OP_RELEASE;
        if ($urandom_range(0, 99) < 10) begin
            p = $urandom_range(0, 7);
            r = $urandom_range(0, 7);
        end else begin
            p    = $urandom_range(0, NUM_AGENTS - 1);
            r    = $urandom_range(0, NUM_AGENTS - 1);
            own  = sb.claim_row(p);
            held = own & ~sb.need[p] & ~sb.avail;
            if ($urandom_range(0, 99) < 75) begin
                if (op == OP_ACQUIRE && own != '0) begin
                    r = pick_bit(own);
                end else if (op == OP_RELEASE && held != '0) begin
                    r = pick_bit(held);
                end
            end
        end
        send_item(op, p, r);
    endtask

    function automatic logic [CLAIM_W-1:0] claim_for_phase(int ph);
        logic [CLAIM_W-1:0] value;
        value = '0;
        case (ph)
            1: value = '1;                                  // everyone claims all
            2: value = CLAIM_W'($urandom());
            3: value = '0;                                  // no claims at all
            4: begin                                        // each owns its own only
                for (int p = 0; p < NUM_AGENTS; p++) value[p*NUM_AGENTS + p] = 1'b1;
            end
            5: begin                                        // back to the ring
                for (int p = 0; p < NUM_AGENTS; p++) begin
                    value[p*NUM_AGENTS + p] = 1'b1;
                    value[p*NUM_AGENTS + (p + 1) % NUM_AGENTS] = 1'b1;
                end
            end
            6: value = CLAIM_W'($urandom()) | CLAIM_W'($urandom());   // dense
            default: value = CLAIM_W'($urandom()) & CLAIM_W'($urandom()); // sparse
        endcase
        return value;
    endfunction

    initial begin
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, under the reset ring claim.
        send_item(OP_ACQUIRE, 0, 0);    // plain grant
        send_item(OP_ACQUIRE, 1, 0);    // resource already taken
        send_item(OP_ACQUIRE, 1, 1);
        send_item(OP_ACQUIRE, 2, 2);
        send_item(OP_ACQUIRE, 3, 3);
        send_item(OP_ACQUIRE, 4, 4);    // closes the ring: unsafe
        send_item(OP_ACQUIRE, 4, 0);
        send_item(OP_RELEASE, 2, 0);    // release of a resource not held
        send_item(OP_RELEASE, 0, 0);
        send_item(OP_ACQUIRE, 7, 1);    // out-of-range process
        send_item(OP_ACQUIRE, 1, 7);    // out-of-range resource
        send_item(OP_ACQUIRE, 5, 5);
        send_item(OP_RELEASE, 6, 2);
        send_item(OP_RELEASE, 3, 5);
        send_item(OP_RELEASE, 7, 7);
        send_item(OP_ACQUIRE, 4, 4);
        send_item(OP_RELEASE, 1, 1);
        send_item(OP_RELEASE, 2, 2);
        send_item(OP_RELEASE, 3, 3);
        send_item(OP_RELEASE, 4, 4);
        send_item(OP_ACQUIRE, 0, 4);    // outside the process's claim
        send_item(OP_ACQUIRE, 4, 0);
        send_item(OP_RELEASE, 4, 0);
        send_item(OP_RELEASE, 0, 4);
        drain();

        // Random part, one claim setting per phase; phase 0 keeps reset claim.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                write_claim_reg(claim_for_phase(ph));
            end
            idle_on = (ph != 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 1 && i == PHASE_ITEMS / 2) begin
                    drain();
                end
                send_random_item();
            end
            drain();
            idle_on = 1'b1;
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
